// ===== sv/ebl_pkg.sv =====
// ----------------------------------------------------------------------------
// ebl_pkg
// Shared types and constants of the envelope adaptive line binarizer.
// ----------------------------------------------------------------------------
`default_nettype none

package ebl_pkg;

    localparam int COL_W     = 12;
    localparam int LEN_W     = 13;
    localparam int PIX_W     = 8;
    localparam int WGT_W     = 7;
    localparam int SUM_W     = 14;
    localparam int PROD_W    = 22;
    localparam int CFG_IDX_W = 1;
    localparam int PIX_DEPTH = 128;
    localparam int PIX_AW    = 7;
    localparam int ENV_DEPTH = 64;
    localparam int ENV_AW    = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT      = 1'd1;

    localparam logic [LEN_W-1:0] LEN_RESET = 13'd2048;
    localparam logic [LEN_W-1:0] LEN_MIN   = 13'd128;
    localparam logic [WGT_W-1:0] WGT_RESET = 7'd70;
    localparam logic [WGT_W-1:0] WGT_MAX   = 7'd100;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             last;
        logic [LEN_W-1:0] len;
    } t_job;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             above;
        logic             last;
    } t_result;

    typedef struct packed {
        logic done;
        logic last;
    } t_retire;

endpackage

`default_nettype wire

// ===== sv/ebl_ram.sv =====
// ----------------------------------------------------------------------------
// ebl_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ebl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== sv/ebl_fifo.sv =====
// ----------------------------------------------------------------------------
// ebl_fifo
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
`default_nettype none

module ebl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire [WIDTH-1:0]  i_data,
    output logic             o_full,
    input  wire              i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             push_ok, pop_ok;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop_ok) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(push_ok) - (AW+1)'(pop_ok);
        end
    end

endmodule

`default_nettype wire

// ===== sv/ebl_front.sv =====
// ----------------------------------------------------------------------------
// ebl_front
// Input side: configuration, pixel store writes, line tracking, job issue.
// ----------------------------------------------------------------------------
`default_nettype none

module ebl_front #(
    parameter int MAX_LINE = 4096
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_push,
    output logic                          o_full,
    input  wire [ebl_pkg::PIX_W-1:0]      i_pixel,
    input  wire                           i_cfg_we,
    input  wire [ebl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [ebl_pkg::LEN_W-1:0]      i_cfg_data,
    output logic                          o_pix_we,
    output logic [ebl_pkg::PIX_AW-1:0]    o_pix_waddr,
    output logic [ebl_pkg::PIX_W-1:0]     o_pix_wdata,
    output logic                          o_job_push,
    output ebl_pkg::t_job                 o_job,
    input  ebl_pkg::t_retire              i_retire,
    output logic [ebl_pkg::WGT_W-1:0]     o_weight
);

    import ebl_pkg::*;

    logic [LEN_W-1:0] r_line_length, r_cur_len, eff_len, len_now;
    logic [WGT_W-1:0] r_weight;
    logic [COL_W-1:0] r_in_col;
    logic [1:0]       r_outstanding;
    logic             r_last_out;
    logic             accept, last;

    always_comb begin
        eff_len = r_line_length;
        if (r_line_length < LEN_MIN) begin
            eff_len = LEN_MIN;
        end else if (r_line_length > LEN_W'(MAX_LINE)) begin
            eff_len = LEN_W'(MAX_LINE);
        end
    end

    assign len_now  = (r_in_col == '0) ? eff_len : r_cur_len;
    assign last     = ({1'b0, r_in_col} >= (len_now - 1'b1));
    assign o_full   = (r_outstanding == 2'd2) || r_last_out;
    assign accept   = i_push && !o_full;
    assign o_weight = (r_weight > WGT_MAX) ? WGT_MAX : r_weight;

    assign o_pix_we    = accept;
    assign o_pix_waddr = r_in_col[PIX_AW-1:0];
    assign o_pix_wdata = i_pixel;
    assign o_job_push  = accept;
    assign o_job       = '{col: r_in_col, last: last, len: len_now};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length <= LEN_RESET;
            r_weight      <= WGT_RESET;
            r_cur_len     <= LEN_RESET;
            r_in_col      <= '0;
            r_outstanding <= '0;
            r_last_out    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_LINE_LENGTH: r_line_length <= i_cfg_data;
                    CFG_WEIGHT:      r_weight      <= i_cfg_data[WGT_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_cur_len <= len_now;
                r_in_col  <= last ? '0 : r_in_col + 1'b1;
            end
            r_outstanding <= r_outstanding + 2'(accept) - 2'(i_retire.done);
            if (accept && last) begin
                r_last_out <= 1'b1;
            end else if (i_retire.done && i_retire.last) begin
                r_last_out <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/ebl_back.sv =====
// ----------------------------------------------------------------------------
// ebl_back
// Execution side: envelope scans, running envelope sums, threshold decisions.
// ----------------------------------------------------------------------------
`default_nettype none

module ebl_back #(
    parameter int ENV_RADIUS = 30,
    parameter int AVG_RADIUS = 30
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_job_empty,
    input  ebl_pkg::t_job               i_job,
    output logic                        o_job_pop,
    output logic [ebl_pkg::PIX_AW-1:0]  o_pix_raddr,
    input  wire [ebl_pkg::PIX_W-1:0]    i_pix_rdata,
    input  wire [ebl_pkg::WGT_W-1:0]    i_weight,
    output logic                        o_res_push,
    output ebl_pkg::t_result            o_res,
    input  wire                         i_res_full,
    output ebl_pkg::t_retire            o_retire
);

    import ebl_pkg::*;

    localparam int WIN_E = 2 * ENV_RADIUS + 1;
    localparam int CNT_W = $clog2(WIN_E + 1);
    localparam logic [LEN_W-1:0] E_R   = LEN_W'(ENV_RADIUS);
    localparam logic [LEN_W-1:0] A_R   = LEN_W'(AVG_RADIUS);
    localparam logic [LEN_W-1:0] A_R2  = LEN_W'(2 * AVG_RADIUS);
    localparam logic [CNT_W-1:0] WIN_C = CNT_W'(WIN_E);
    localparam logic [PROD_W-1:0] LHS_K = PROD_W'(100 * (2 * AVG_RADIUS + 1));

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_CHECK    = 7'b0000010,
        S_ENV      = 7'b0000100,
        S_ENV_DONE = 7'b0001000,
        S_DEC_RD   = 7'b0010000,
        S_DEC_MUL  = 7'b0100000,
        S_DEC_OUT  = 7'b1000000
    } t_state;

    t_state            r_state;
    t_job              r_job;
    logic [COL_W-1:0]  r_out_col, r_cc, r_k, r_p;
    logic [SUM_W-1:0]  r_su, r_sl;
    logic              r_init, r_rd_vld;
    logic [CNT_W-1:0]  r_issued, r_got;
    logic [PIX_W-1:0]  r_hi, r_lo;
    logic [PROD_W-1:0] r_lhs, r_m1, r_m2;

    logic [LEN_W-1:0]     len, col_x, cc_x, t_x;
    logic                 emit;
    logic [2*PIX_W-1:0]   env_rdata;
    logic                 env_we;
    logic [PIX_W-1:0]     hi_x, lo_x;

    function automatic logic [COL_W-1:0] env_first(input logic [COL_W-1:0] k,
                                                   input logic [LEN_W-1:0] l);
        logic [LEN_W-1:0] kk;
        kk = {1'b0, k};
        if (kk < E_R) begin
            kk = E_R;
        end else if (kk > l - 1'b1 - E_R) begin
            kk = l - 1'b1 - E_R;
        end
        return COL_W'(kk - E_R);
    endfunction

    assign len   = r_job.len;
    assign col_x = {1'b0, r_out_col};

    always_comb begin
        cc_x = col_x;
        if (col_x < A_R) begin
            cc_x = A_R;
        end else if (col_x > len - 1'b1 - A_R) begin
            cc_x = len - 1'b1 - A_R;
        end
        t_x = col_x + A_R;
        if (t_x < A_R2) begin
            t_x = A_R2;
        end
        if (t_x < E_R) begin
            t_x = E_R;
        end
        emit = (col_x < len) &&
               (r_job.last || ({1'b0, t_x} + {1'b0, E_R} <= {2'b0, r_job.col}));
    end

    always_comb begin
        hi_x = r_hi;
        lo_x = r_lo;
        if (r_rd_vld) begin
            if (i_pix_rdata > r_hi) hi_x = i_pix_rdata;
            if (i_pix_rdata < r_lo) lo_x = i_pix_rdata;
        end
    end

    assign o_pix_raddr = (r_state == S_DEC_RD) ? r_out_col[PIX_AW-1:0] : r_p[PIX_AW-1:0];
    assign env_we      = (r_state == S_ENV_DONE);
    assign o_job_pop   = (r_state == S_IDLE) && !i_job_empty;
    assign o_res_push  = (r_state == S_DEC_OUT) && !i_res_full;
    assign o_res       = '{col: r_out_col,
                           above: (r_lhs > (r_m1 + r_m2)),
                           last: (col_x == len - 1'b1)};
    assign o_retire    = '{done: (r_state == S_CHECK) && !emit, last: r_job.last};

    ebl_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (ENV_DEPTH)
    ) u_env_ram (
        .i_clk   (i_clk),
        .i_we    (env_we),
        .i_waddr (r_k[ENV_AW-1:0]),
        .i_wdata ({r_hi, r_lo}),
        .i_raddr (ENV_AW'(r_cc - COL_W'(AVG_RADIUS))),
        .o_rdata (env_rdata)
    );

    always_ff @(posedge i_clk) begin
        r_rd_vld <= (r_state == S_ENV) && (r_issued < WIN_C);
        if (r_state == S_DEC_MUL) begin
            r_lhs <= PROD_W'(i_pix_rdata) * LHS_K;
            r_m1  <= PROD_W'(WGT_MAX - i_weight) * PROD_W'(r_su);
            r_m2  <= PROD_W'(i_weight) * PROD_W'(r_sl);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_col <= '0;
            r_job     <= '0;
            r_cc      <= '0;
            r_k       <= '0;
            r_p       <= '0;
            r_su      <= '0;
            r_sl      <= '0;
            r_init    <= 1'b0;
            r_issued  <= '0;
            r_got     <= '0;
            r_hi      <= '0;
            r_lo      <= '1;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_job_empty) begin
                        r_job   <= i_job;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_issued <= '0;
                    r_got    <= '0;
                    r_hi     <= '0;
                    r_lo     <= '1;
                    if (!emit) begin
                        if (r_job.last) r_out_col <= '0;
                        r_state <= S_IDLE;
                    end else if (r_out_col == '0) begin
                        r_init  <= 1'b1;
                        r_k     <= '0;
                        r_p     <= env_first('0, len);
                        r_su    <= '0;
                        r_sl    <= '0;
                        r_state <= S_ENV;
                    end else if (COL_W'(cc_x) != r_cc) begin
                        r_init  <= 1'b0;
                        r_k     <= r_cc + COL_W'(AVG_RADIUS) + 1'b1;
                        r_p     <= env_first(r_cc + COL_W'(AVG_RADIUS) + 1'b1, len);
                        r_state <= S_ENV;
                    end else begin
                        r_state <= S_DEC_RD;
                    end
                end
                S_ENV: begin
                    if (r_issued < WIN_C) begin
                        r_p      <= r_p + 1'b1;
                        r_issued <= r_issued + 1'b1;
                    end
                    r_hi <= hi_x;
                    r_lo <= lo_x;
                    if (r_rd_vld) begin
                        r_got <= r_got + 1'b1;
                        if (r_got == WIN_C - 1'b1) r_state <= S_ENV_DONE;
                    end
                end
                S_ENV_DONE: begin
                    r_issued <= '0;
                    r_got    <= '0;
                    r_hi     <= '0;
                    r_lo     <= '1;
                    if (r_init) begin
                        r_su <= r_su + SUM_W'(r_hi);
                        r_sl <= r_sl + SUM_W'(r_lo);
                        if (r_k == COL_W'(2 * AVG_RADIUS)) begin
                            r_cc    <= COL_W'(AVG_RADIUS);
                            r_state <= S_DEC_RD;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_p     <= env_first(r_k + 1'b1, len);
                            r_state <= S_ENV;
                        end
                    end else begin
                        r_su    <= r_su + SUM_W'(r_hi) - SUM_W'(env_rdata[2*PIX_W-1:PIX_W]);
                        r_sl    <= r_sl + SUM_W'(r_lo) - SUM_W'(env_rdata[PIX_W-1:0]);
                        r_cc    <= r_cc + 1'b1;
                        r_state <= S_DEC_RD;
                    end
                end
                S_DEC_RD: begin
                    r_state <= S_DEC_MUL;
                end
                S_DEC_MUL: begin
                    r_state <= S_DEC_OUT;
                end
                S_DEC_OUT: begin
                    if (!i_res_full) begin
                        r_out_col <= r_out_col + 1'b1;
                        r_state   <= S_CHECK;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/envelope_adaptive_line_binarizer_top.sv =====
// ----------------------------------------------------------------------------
// envelope_adaptive_line_binarizer_top
// Marks each pixel of a scan line above or below a threshold taken from the
// smoothed min/max envelopes of the line.
//
// Input queue: push one pixel while full is low; lines follow back to back.
// Result queue: one item per column, in column order, while empty is low;
// pop takes it. The last pixel of a line flushes all columns still pending.
// Configuration: write line_length (index 0) or weight_min_percent (index 1)
// with i_cfg_we while the block is idle; the line length applies from the
// next line start.
// Work per column: a column that moves the envelope window costs one scan of
// 2*ENV_RADIUS+1 reads of the single pixel RAM read port plus the check and
// decision states; a column near a line edge needs no scan; the first column
// of a line runs 2*AVG_RADIUS+1 scans.
// At most two pixels wait ahead of the back end; after the last pixel of a
// line, input stays full until that line is flushed.
// Reset clears counters and queues and restores the register defaults;
// a stalled result queue holds the back end, which then holds the input.
// ----------------------------------------------------------------------------
`default_nettype none

module envelope_adaptive_line_binarizer_top #(
    parameter int ENV_RADIUS = 30,
    parameter int AVG_RADIUS = 30,
    parameter int MAX_LINE   = 4096
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           push,
    output logic                          full,
    input  wire [ebl_pkg::PIX_W-1:0]      i_pixel,
    input  wire                           i_cfg_we,
    input  wire [ebl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [ebl_pkg::LEN_W-1:0]      i_cfg_data,
    output logic                          empty,
    input  wire                           pop,
    output logic [ebl_pkg::COL_W-1:0]     o_column,
    output logic                          o_above,
    output logic                          o_last_of_line
);

    import ebl_pkg::*;

    logic              pix_we;
    logic [PIX_AW-1:0] pix_waddr, pix_raddr;
    logic [PIX_W-1:0]  pix_wdata, pix_rdata;
    logic              job_push, job_pop, job_empty;
    t_job              job_in, job_out;
    t_retire           retire;
    logic [WGT_W-1:0]  weight;
    logic              res_push, res_full;
    t_result           res_in, res_out;

    ebl_front #(
        .MAX_LINE (MAX_LINE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_pixel     (i_pixel),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_pix_we    (pix_we),
        .o_pix_waddr (pix_waddr),
        .o_pix_wdata (pix_wdata),
        .o_job_push  (job_push),
        .o_job       (job_in),
        .i_retire    (retire),
        .o_weight    (weight)
    );

    ebl_ram #(
        .WIDTH (PIX_W),
        .DEPTH (PIX_DEPTH)
    ) u_pix_ram (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_waddr (pix_waddr),
        .i_wdata (pix_wdata),
        .i_raddr (pix_raddr),
        .o_rdata (pix_rdata)
    );

    ebl_fifo #(
        .WIDTH ($bits(t_job)),
        .DEPTH (2)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty)
    );

    ebl_back #(
        .ENV_RADIUS (ENV_RADIUS),
        .AVG_RADIUS (AVG_RADIUS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .o_pix_raddr (pix_raddr),
        .i_pix_rdata (pix_rdata),
        .i_weight    (weight),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .i_res_full  (res_full),
        .o_retire    (retire)
    );

    ebl_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_column       = res_out.col;
    assign o_above        = res_out.above;
    assign o_last_of_line = res_out.last;

endmodule

`default_nettype wire
